// ----- rtl/u8v_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8v_pkg - shared types and constants for the UTF-8 stream validator
// Beat structs for both channels and the byte-range limits of the checker.
// ----------------------------------------------------------------------------
package u8v_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} byte_beat_t;

	typedef struct packed {
		logic no_error_yet;
		logic sequence_closed;
		logic string_valid;
		logic last_result;
	} result_beat_t;

	// continuation range and its narrowed forms
	localparam logic [7:0] CONT_LO     = 8'h80;
	localparam logic [7:0] CONT_HI     = 8'hBF;
	localparam logic [7:0] E0_CONT_LO  = 8'hA0;
	localparam logic [7:0] ED_CONT_HI  = 8'h9F;
	localparam logic [7:0] F0_CONT_LO  = 8'h90;
	localparam logic [7:0] F4_CONT_HI  = 8'h8F;

	// lead byte boundaries
	localparam logic [7:0] LEAD_ASCII_END = 8'h80;
	localparam logic [7:0] LEAD_MIN       = 8'hC2;
	localparam logic [7:0] LEAD_3B_MIN    = 8'hE0;
	localparam logic [7:0] LEAD_4B_MIN    = 8'hF0;
	localparam logic [7:0] LEAD_MAX       = 8'hF4;
	localparam logic [7:0] LEAD_E0        = 8'hE0;
	localparam logic [7:0] LEAD_ED        = 8'hED;
	localparam logic [7:0] LEAD_F0        = 8'hF0;
	localparam logic [7:0] LEAD_F4        = 8'hF4;

endpackage

// ----- rtl/u8v_in_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8v_in_reg - input register stage
// Captures one byte beat; frees itself whenever the beat moves on.
// ----------------------------------------------------------------------------
module u8v_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  u8v_pkg::byte_beat_t byte_beat,
	input  logic                advance,
	output logic                valid_s1,
	output u8v_pkg::byte_beat_t beat_s1
);

	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			beat_s1 <= byte_beat;
		end
	end

endmodule

// ----- rtl/u8v_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8v_check - sequence tracker
// Holds the open-sequence state and works out the result for one byte.
// ----------------------------------------------------------------------------
module u8v_check (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  u8v_pkg::byte_beat_t   beat_s1,
	output u8v_pkg::result_beat_t result
);

	logic [1:0] cont_left_q;
	logic [7:0] low_q;
	logic [7:0] high_q;
	logic       err_q;

	logic [1:0] cont_left_d;
	logic [7:0] low_d;
	logic [7:0] high_d;
	logic       err_d;
	logic [7:0] b;

	assign b = beat_s1.data_byte;

	always_comb begin
		cont_left_d = 2'd0;
		low_d       = u8v_pkg::CONT_LO;
		high_d      = u8v_pkg::CONT_HI;
		err_d       = err_q;
		if (cont_left_q == 2'd0) begin
			// lead byte
			if (b >= u8v_pkg::LEAD_ASCII_END) begin
				if (b < u8v_pkg::LEAD_MIN || b > u8v_pkg::LEAD_MAX) begin
					err_d = 1'b1;
				end else if (b < u8v_pkg::LEAD_3B_MIN) begin
					cont_left_d = 2'd1;
				end else if (b < u8v_pkg::LEAD_4B_MIN) begin
					cont_left_d = 2'd2;
					if (b == u8v_pkg::LEAD_E0) low_d  = u8v_pkg::E0_CONT_LO;
					if (b == u8v_pkg::LEAD_ED) high_d = u8v_pkg::ED_CONT_HI;
				end else begin
					cont_left_d = 2'd3;
					if (b == u8v_pkg::LEAD_F0) low_d  = u8v_pkg::F0_CONT_LO;
					if (b == u8v_pkg::LEAD_F4) high_d = u8v_pkg::F4_CONT_HI;
				end
			end
		end else begin
			// continuation; a bad one abandons the sequence
			if (b < low_q || b > high_q) begin
				err_d = 1'b1;
			end else begin
				cont_left_d = cont_left_q - 2'd1;
			end
		end
	end

	always_comb begin
		result.no_error_yet    = !err_d;
		result.sequence_closed = (cont_left_d == 2'd0);
		result.string_valid    = beat_s1.end_of_string && !err_d && (cont_left_d == 2'd0);
		result.last_result     = beat_s1.end_of_string;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_left_q <= 2'd0;
			low_q       <= u8v_pkg::CONT_LO;
			high_q      <= u8v_pkg::CONT_HI;
			err_q       <= 1'b0;
		end else if (advance) begin
			if (beat_s1.end_of_string) begin
				cont_left_q <= 2'd0;
				low_q       <= u8v_pkg::CONT_LO;
				high_q      <= u8v_pkg::CONT_HI;
				err_q       <= 1'b0;
			end else begin
				cont_left_q <= cont_left_d;
				low_q       <= low_d;
				high_q      <= high_d;
				err_q       <= err_d;
			end
		end
	end

endmodule

// ----- rtl/u8v_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8v_out_reg - result register stage
// Holds one result beat until taken; asks for the next while empty or draining.
// ----------------------------------------------------------------------------
module u8v_out_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  u8v_pkg::result_beat_t result,
	output logic                  advance,
	output logic                  result_valid,
	input  logic                  result_ready,
	output u8v_pkg::result_beat_t result_beat
);

	logic                  valid_s2;
	u8v_pkg::result_beat_t beat_s2;

	assign advance      = valid_s1 && (!valid_s2 || result_ready);
	assign result_valid = valid_s2;
	assign result_beat  = beat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			beat_s2 <= result;
		end
	end

endmodule

// ----- rtl/utf8_stream_validator.sv -----
`timescale 1ns / 1ps
// Path: an accepted byte beat goes into the input register, and its result into the result register.
// Throughput: one byte per clock unless the result side stalls; the input and
// result registers let a new beat in while a finished result still waits.
// Reset: arst_n clears both stage valids and the sequence state at once.
// The sequence state also returns to its reset values after the last byte.
// ----------------------------------------------------------------------------
// utf8_stream_validator - streaming UTF-8 well-formedness check
// One byte per beat, end_of_string on the final byte; one result per byte.
// ----------------------------------------------------------------------------
module utf8_stream_validator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  u8v_pkg::byte_beat_t   byte_beat,
	output logic                  result_valid,
	input  logic                  result_ready,
	output u8v_pkg::result_beat_t result_beat
);

	// Stage 1 holds the raw byte; the tracker looks at it against the
	// sequence state and the outcome lands in stage 2 on the same edge that
	// commits the new state. 'advance' is that edge's enable.
	logic                  advance;
	logic                  valid_s1;
	u8v_pkg::byte_beat_t   beat_s1;
	u8v_pkg::result_beat_t result;

	u8v_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_beat  (byte_beat),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.beat_s1    (beat_s1)
	);

	// Lead / continuation decode, narrowed bounds after E0, ED, F0, F4,
	// sticky error flag per string.
	u8v_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.beat_s1 (beat_s1),
		.result  (result)
	);

	u8v_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.result       (result),
		.advance      (advance),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_beat  (result_beat)
	);

endmodule

// ----- rtl/u8v_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8v_checker - port-level checks for the UTF-8 stream validator
// Watches the handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module u8v_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  byte_valid,
	input logic                  byte_ready,
	input u8v_pkg::byte_beat_t   byte_beat,
	input logic                  result_valid,
	input logic                  result_ready,
	input u8v_pkg::result_beat_t result_beat
);

	// a byte beat on offer holds until taken
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(byte_beat))
		else $error("byte beat changed while stalled");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_beat))
		else $error("result beat changed while stalled");

	// a fresh result traces back to an accepted byte through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(byte_valid && byte_ready, 2))
		else $error("result appeared without a matching byte");

	// input only back-pressures when the result side is stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> result_valid && !result_ready)
		else $error("input stalled while result side free");

	// a valid-string verdict needs the last byte, no error and no open sequence
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_beat.string_valid |->
			result_beat.last_result && result_beat.no_error_yet &&
			result_beat.sequence_closed)
		else $error("string_valid inconsistent with other flags");

endmodule

bind utf8_stream_validator u8v_checker u_u8v_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_ready   (byte_ready),
	.byte_beat    (byte_beat),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_beat  (result_beat)
);
